>>> src/rrs_pkg.sv
package rrs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [15:0] QUANTUM_RESET = 16'd2;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'd0,
        ST_REFUSE = 3'd1,
        ST_IDLE   = 3'd2,
        ST_RAN    = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [15:0] remaining;
        logic [31:0] arrival;
        logic [31:0] start_t;
        logic        started;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

>>> src/rrs_ram.sv
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/rrs_ctrl.sv
module rrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               cfg_ready,
    output rrs_pkg::ctrl_cmd_t ctrl
);
    import rrs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        cfg_ready    = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready    = 1'b1;
                ctrl.capture = start;
            end
            S_EXEC:
            begin
                busy         = 1'b1;
                ctrl.execute = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && ctrl.execute))
        else $error("accepted word did not enter execute");
    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute lasted more than one cycle");
`endif

endmodule

>>> src/rrs_datapath.sv
module rrs_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rrs_pkg::ctrl_cmd_t ctrl,
    input  logic               cmd,
    input  logic [15:0]        burst_length,
    input  logic               cfg_wr,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic [2:0]         status,
    output logic [31:0]        turnaround,
    output logic [31:0]        response,
    output logic [31:0]        run_span
);
    import rrs_pkg::*;

    logic             cmd_reg;
    logic [15:0]      burst_reg;
    logic [15:0]      quantum_reg;
    logic [15:0]      qleft_reg, qleft_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      time_reg, time_next;

    logic             done_reg;
    status_t          status_reg, status_next;
    logic [31:0]      turn_reg, turn_next;
    logic [31:0]      resp_reg, resp_next;
    logic [31:0]      span_reg, span_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wentry;
    entry_t           rentry;
    logic [ENTRY_W-1:0] rdata;

    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] head_inc;
    logic [15:0]      reload_val;
    logic [15:0]      rem_dec;
    logic [15:0]      qleft_dec;
    logic [31:0]      start_val;

    rrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (head_reg),
        .rdata (rdata)
    );

    assign rentry = entry_t'(rdata);

    // circular slot arithmetic, sum stays below twice the depth
    assign tail_sum = {1'b0, head_reg} + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S)
                                            : IDX_W'(tail_sum);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    assign reload_val = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign rem_dec    = (rentry.remaining != 16'd0) ? rentry.remaining - 16'd1 : 16'd0;
    assign qleft_dec  = (qleft_reg != 16'd0) ? qleft_reg - 16'd1 : 16'd0;
    assign start_val  = rentry.started ? rentry.start_t : time_reg;

    always_comb
    begin
        qleft_next  = qleft_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        status_next = ST_IDLE;
        turn_next   = '0;
        resp_next   = '0;
        span_next   = '0;
        we          = 1'b0;
        waddr       = head_reg;
        wentry      = '{remaining: rem_dec, arrival: rentry.arrival,
                        start_t: start_val, started: 1'b1};
        if (cmd_t'(cmd_reg) == CMD_ARRIVE)
        begin
            if (count_reg == DEPTH_C || burst_reg == 16'd0)
            begin
                status_next = ST_REFUSE;
            end
            else
            begin
                status_next = ST_ACCEPT;
                we          = 1'b1;
                waddr       = tail_idx;
                wentry      = '{remaining: burst_reg, arrival: time_reg,
                                start_t: 32'd0, started: 1'b0};
                count_next  = count_reg + 1'b1;
            end
        end
        else
        begin
            time_next = time_reg + 32'd1;
            if (count_reg == '0)
            begin
                status_next = ST_IDLE;
                qleft_next  = reload_val;
            end
            else if (rem_dec == 16'd0)
            begin
                status_next = ST_DONE;
                turn_next   = time_reg - rentry.arrival + 32'd1;
                resp_next   = start_val - rentry.arrival;
                span_next   = time_reg - start_val + 32'd1;
                head_next   = head_inc;
                count_next  = count_reg - 1'b1;
                qleft_next  = reload_val;
            end
            else
            begin
                status_next = ST_RAN;
                we          = 1'b1;
                if (qleft_dec == 16'd0)
                begin
                    qleft_next = reload_val;
                    // rotate head job to the tail when others wait
                    if (count_reg > CNT_W'(1))
                    begin
                        waddr     = tail_idx;
                        head_next = head_inc;
                    end
                end
                else
                begin
                    qleft_next = qleft_dec;
                end
            end
        end
        if (!ctrl.execute)
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= cmd;
            burst_reg <= burst_length;
        end
        if (ctrl.execute)
        begin
            status_reg <= status_next;
            turn_reg   <= turn_next;
            resp_reg   <= resp_next;
            span_reg   <= span_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
            qleft_reg   <= QUANTUM_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            time_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                quantum_reg <= cfg_data;
            end
            done_reg <= ctrl.execute;
            if (ctrl.execute)
            begin
                qleft_reg <= qleft_next;
                head_reg  <= head_next;
                count_reg <= count_next;
                time_reg  <= time_next;
            end
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign turnaround = turn_reg;
    assign response   = resp_reg;
    assign run_span   = span_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");
    a_spans_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_DONE) |->
            (turn_reg == '0 && resp_reg == '0 && span_reg == '0))
        else $error("spans nonzero without completion");
`endif

endmodule

>>> src/round_robin_scheduler_core.sv
// round-robin job scheduler with a circular ready queue held in a small ram
// command channel: a word is taken when start is high and busy is low;
// cmd selects arrive (append job of burst_length units) or tick (run head
// job for one time unit, then advance time)
// result channel: done strobes for one cycle with status, and on job
// completion turnaround, response and run_span (zero otherwise); the
// receiver cannot stall, every result must be taken in its cycle
// config channel: cfg_data writes the quantum when cfg_valid and cfg_ready
// are both high; ready is high whenever no command is executing, and the
// new value is used at the next quantum reload
// timing: an accepted command enters execute in the next cycle, and done
// follows in the cycle after execute; busy is high during execute only, so
// a command is not taken during execute, only in the idle state between,
// as the registered read of the head entry must follow its write back
// reset: queue empty, time zero, quantum 2; queue ram contents are not
// cleared, only slots written by arrivals are ever read
module round_robin_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] burst_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] turnaround,
    output logic [31:0] response,
    output logic [31:0] run_span
);
    import rrs_pkg::*;

    ctrl_cmd_t ctrl;
    logic      cfg_wr;

    assign cfg_wr = cfg_valid && cfg_ready;

    rrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .ctrl      (ctrl)
    );

    rrs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .burst_length (burst_length),
        .cfg_wr       (cfg_wr),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .turnaround   (turnaround),
        .response     (response),
        .run_span     (run_span)
    );

endmodule

>>> bench/round_robin_scheduler_core_tb.sv
`timescale 1ns / 100ps

module round_robin_scheduler_core_tb;

    import rrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int N_DIRECTED = 25;

    typedef struct packed {
        status_t     st;
        logic [31:0] turn;
        logic [31:0] resp;
        logic [31:0] span;
    } sched_res_t;

    typedef struct packed {
        cmd_t        op;
        logic [15:0] burst;
        logic        typed;
        sched_res_t  want;
    } dir_row_t;

    localparam sched_res_t UNTYPED = '{ST_ACCEPT, 32'd0, 32'd0, 32'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_ARRIVE;
    logic [15:0] burst_length = 16'd0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] turnaround;
    logic [31:0] response;
    logic [31:0] run_span;

    // shadow of the ready queue and timers
    logic [15:0] job_work [QUEUE_DEPTH];
    logic [31:0] job_arrive [QUEUE_DEPTH];
    logic [31:0] job_first [QUEUE_DEPTH];
    logic        job_started [QUEUE_DEPTH];
    int          q_head = 0;
    int          q_count = 0;
    logic [31:0] now_t = 32'd0;
    logic [15:0] slice_left = QUANTUM_RESET;
    logic [15:0] quantum_reg = QUANTUM_RESET;

    sched_res_t  pending_res [$];
    int          fail_cnt = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          status_seen [5] = '{0, 0, 0, 0, 0};
    int          quiet_cycles = 0;
    int          settings_used = 1;

    dir_row_t    dir_tab [N_DIRECTED];

    round_robin_scheduler_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .burst_length(burst_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .status(status),
        .turnaround(turnaround),
        .response(response),
        .run_span(run_span)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] full_slice();
        return (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    endfunction

    task automatic schedule_step(input cmd_t c, input logic [15:0] b, output sched_res_t r);
        int h;
        int t;
        r = '{ST_ACCEPT, 32'd0, 32'd0, 32'd0};
        if (c == CMD_ARRIVE)
        begin
            if (q_count >= QUEUE_DEPTH || b == 16'd0)
            begin
                r.st = ST_REFUSE;
            end
            else
            begin
                t = (q_head + q_count) % QUEUE_DEPTH;
                job_work[t] = b;
                job_arrive[t] = now_t;
                job_first[t] = 32'd0;
                job_started[t] = 1'b0;
                q_count++;
            end
        end
        else if (q_count == 0)
        begin
            r.st = ST_IDLE;
            slice_left = full_slice();
            now_t++;
        end
        else
        begin
            h = q_head;
            if (!job_started[h])
            begin
                job_started[h] = 1'b1;
                job_first[h] = now_t;
            end
            if (job_work[h] != 16'd0)
                job_work[h]--;
            if (job_work[h] == 16'd0)
            begin
                r.st = ST_DONE;
                r.turn = now_t - job_arrive[h] + 32'd1;
                r.resp = job_first[h] - job_arrive[h];
                r.span = now_t - job_first[h] + 32'd1;
                q_head = (h + 1) % QUEUE_DEPTH;
                q_count--;
                slice_left = full_slice();
            end
            else
            begin
                r.st = ST_RAN;
                if (slice_left != 16'd0)
                    slice_left--;
                if (slice_left == 16'd0)
                begin
                    slice_left = full_slice();
                    // slice used up: head job moves to the tail slot
                    if (q_count > 1)
                    begin
                        t = (q_head + q_count) % QUEUE_DEPTH;
                        job_work[t] = job_work[h];
                        job_arrive[t] = job_arrive[h];
                        job_first[t] = job_first[h];
                        job_started[t] = job_started[h];
                        q_head = (h + 1) % QUEUE_DEPTH;
                    end
                end
            end
            now_t++;
        end
    endtask

    // start stays high across back-to-back words, dropped only for a gap
    task automatic issue_word(input cmd_t c, input logic [15:0] b, input logic typed,
                              input sched_res_t typed_res, input int gap);
        sched_res_t pr;
        start <= 1'b1;
        cmd <= c;
        burst_length <= b;
        do @(posedge clk); while (busy);
        schedule_step(c, b, pr);
        pending_res.push_back(typed ? typed_res : pr);
        words_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_quantum(input logic [15:0] v);
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        quantum_reg = v;
        settings_used++;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // results are sampled at the edge that ends their strobe cycle
    always @(posedge clk)
    begin
        sched_res_t w;
        if (rst_n && done)
        begin
            results_seen++;
            if (status < 3'd5)
                status_seen[status]++;
            if (pending_res.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result word, expected none got status %0d",
                         $time, status);
            end
            else
            begin
                w = pending_res.pop_front();
                report_field("status", 32'(w.st), 32'(status));
                report_field("turnaround", w.turn, turnaround);
                report_field("response", w.resp, response);
                report_field("run_span", w.span, run_span);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int          idle_pct;
        int          arrive_pct;
        int          gap;
        int          sel;
        cmd_t        c;
        logic [15:0] b;
        logic [15:0] phase_q [6];

        dir_tab = '{
            '{CMD_TICK,   16'd0,     1'b1, '{ST_IDLE,   32'd0, 32'd0, 32'd0}},
            '{CMD_ARRIVE, 16'd0,     1'b1, '{ST_REFUSE, 32'd0, 32'd0, 32'd0}},
            '{CMD_ARRIVE, 16'd1,     1'b1, '{ST_ACCEPT, 32'd0, 32'd0, 32'd0}},
            '{CMD_TICK,   16'hffff,  1'b1, '{ST_DONE,   32'd1, 32'd0, 32'd1}},
            '{CMD_ARRIVE, 16'hffff,  1'b1, '{ST_ACCEPT, 32'd0, 32'd0, 32'd0}},
            '{CMD_ARRIVE, 16'd3,     1'b1, '{ST_ACCEPT, 32'd0, 32'd0, 32'd0}},
            // two slices of two units: both jobs rotate once
            '{CMD_TICK,   16'd0,     1'b0, UNTYPED},
            '{CMD_TICK,   16'h5555,  1'b0, UNTYPED},
            '{CMD_TICK,   16'haaaa,  1'b0, UNTYPED},
            '{CMD_TICK,   16'd0,     1'b0, UNTYPED},
            // fill the queue up to its depth
            '{CMD_ARRIVE, 16'd1,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd2,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd3,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd1,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd2,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd3,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd1,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd2,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd3,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd1,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd2,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd3,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd1,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'd2,     1'b0, UNTYPED},
            '{CMD_ARRIVE, 16'hffff,  1'b1, '{ST_REFUSE, 32'd0, 32'd0, 32'd0}}
        };
        phase_q = '{QUANTUM_RESET, 16'd1, 16'hffff, 16'd0, 16'd3, 16'd0};
        phase_q[5] = 16'($urandom_range(1, 8));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            issue_word(dir_tab[i].op, dir_tab[i].burst, dir_tab[i].typed, dir_tab[i].want,
                       (i == N_DIRECTED - 1) ? 1 : 0);

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                set_quantum(phase_q[p]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 72;
                default: idle_pct = 33;
            endcase
            arrive_pct = 35;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // swing between filling and draining the queue
                if (n % 50 == 0)
                begin
                    case ($urandom_range(2))
                        0: arrive_pct = 20;
                        1: arrive_pct = 35;
                        default: arrive_pct = 60;
                    endcase
                end
                if ($urandom_range(99) < arrive_pct)
                begin
                    c = CMD_ARRIVE;
                    sel = $urandom_range(99);
                    if (sel < 5)
                        b = 16'd0;
                    else if (q_count >= QUEUE_DEPTH || sel < 6)
                        b = 16'($urandom);
                    else
                        b = 16'($urandom_range(1, 4));
                end
                else
                begin
                    c = CMD_TICK;
                    b = 16'($urandom);
                end
                gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
                if (n == ITEMS_PER_PHASE - 1)
                    gap = 1;
                issue_word(c, b, 1'b0, UNTYPED, gap);
            end
        end

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d command words over %0d quantum settings, %0d result words checked",
                 words_sent, settings_used, results_seen);
        $display("accepted %0d, refused %0d, idle %0d, ran %0d, completed %0d",
                 status_seen[ST_ACCEPT], status_seen[ST_REFUSE], status_seen[ST_IDLE],
                 status_seen[ST_RAN], status_seen[ST_DONE]);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
src/rrs_pkg.sv
src/rrs_ram.sv
src/rrs_ctrl.sv
src/rrs_datapath.sv
src/round_robin_scheduler_core.sv
bench/round_robin_scheduler_core_tb.sv
